// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file of the packed counter multiset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define PCM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PCM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/pcm_pkg.sv -----
// Types and constants of the packed counter multiset.
package pcm_pkg;

   localparam int PCM_MAX_ELEMENTS = 1024;

   localparam int ACTION_WIDTH    = 2;
   localparam int ELEMENT_WIDTH   = 10;
   localparam int AMOUNT_WIDTH    = 8;
   localparam int OCC_WIDTH       = 8;
   localparam int STATUS_WIDTH    = 2;
   localparam int K_WIDTH         = 4;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 10;
   localparam int SPAN_WIDTH      = ELEMENT_WIDTH + K_WIDTH;
   localparam int SHIFT_WIDTH     = 4;
   localparam int WINDOW_WIDTH    = 16;

   localparam logic [K_WIDTH-1:0]       K_RESET       = 4'd4;
   localparam logic [K_WIDTH-1:0]       K_LARGEST     = 4'd8;
   localparam logic [ELEMENT_WIDTH-1:0] LARGEST_RESET = 10'd1023;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACTION_QUERY      = 2'd0,
      ACTION_ADD_ONE    = 2'd1,
      ACTION_ADD_AMOUNT = 2'd2
   } action_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK           = 2'd0,
      STATUS_SATURATED    = 2'd1,
      STATUS_OUT_OF_RANGE = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COUNTER_BITS    = 1'b0,
      CSR_LARGEST_ELEMENT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } state_type;

endpackage

// ----- hdl/pcm_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module pcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/packed_counter_multiset.sv -----
// Packed counter multiset: K-bit saturating occurrence counters in a byte store.
//
// A command is taken when start is high and busy is low; its single result
// appears on the rsp_ ports after the update state and the response registers
// for exactly one cycle, marked by rsp_valid, and cannot be held off. The
// counter's two bytes are read from an even and an odd byte bank in the cycle
// of acceptance and modified and written back in the next; busy stays high
// through that read-modify-write, so a new command waits until it is done.
// After reset the store is cleared one row of both banks per cycle, which
// keeps busy high until every row is cleared. Register writes are always taken.
module packed_counter_multiset import pcm_pkg::*; #(
   parameter int MAX_ELEMENTS = PCM_MAX_ELEMENTS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [ACTION_WIDTH-1:0]    req_action,
   input  logic [ELEMENT_WIDTH-1:0]   req_element,
   input  logic [AMOUNT_WIDTH-1:0]    req_amount,
   output logic                       rsp_valid,
   output logic [OCC_WIDTH-1:0]       rsp_occurrences,
   output logic [STATUS_WIDTH-1:0]    rsp_status,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   localparam int DEPTH = (MAX_ELEMENTS + 1) / 2;
   localparam int RW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int BW    = (RW + 1 > ELEMENT_WIDTH + 1) ? RW + 1 : ELEMENT_WIDTH + 1;

   state_type state_ff, state_in;
   logic      clearing, updating, accept;

   logic [RW-1:0] clr_row_ff, clr_row_in;

   logic [K_WIDTH-1:0]       counter_bits_ff, counter_bits_in;
   logic [ELEMENT_WIDTH-1:0] largest_element_ff, largest_element_in;

   logic [K_WIDTH-1:0]    k_now;
   logic [SPAN_WIDTH-1:0] span;
   logic [BW-1:0]         byte_idx, row_base, row_plus;
   logic [RW-1:0]         even_rd_addr, odd_rd_addr;
   logic [OCC_WIDTH-1:0]  top_now;
   logic [SHIFT_WIDTH-1:0] sh_now;
   logic                  range_now, low_now;

   action_type             action_ff, action_in;
   logic [AMOUNT_WIDTH-1:0] amount_ff, amount_in;
   logic [OCC_WIDTH-1:0]   top_ff, top_in;
   logic [SHIFT_WIDTH-1:0] sh_ff, sh_in;
   logic                   odd_first_ff, odd_first_in;
   logic                   low_ok_ff, low_ok_in;
   logic                   range_ok_ff, range_ok_in;
   logic [RW-1:0]          even_addr_ff, even_addr_in;
   logic [RW-1:0]          odd_addr_ff, odd_addr_in;

   logic [7:0]              even_q, odd_q, hi_byte, lo_byte;
   logic [WINDOW_WIDTH-1:0] window, window_new, mask16;
   logic [OCC_WIDTH-1:0]    cur, add, room, nxt;
   logic                    do_write;

   logic          even_we, odd_we;
   logic [RW-1:0] even_wr_addr, odd_wr_addr;
   logic [7:0]    even_wr_data, odd_wr_data;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OCC_WIDTH-1:0] rsp_occ_ff, rsp_occ_in;
   status_type           rsp_status_ff, rsp_status_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_row_ff == RW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      clearing = (state_ff == ST_CLEAR);
      updating = (state_ff == ST_UPDATE);
      busy     = (state_ff != ST_IDLE);
      accept   = start && (state_ff == ST_IDLE);
   end

   assign clr_row_in = clearing ? clr_row_ff + RW'(1) : clr_row_ff;
   assign csr_ready  = 1'b1;

   always_comb begin
      counter_bits_in    = counter_bits_ff;
      largest_element_in = largest_element_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_COUNTER_BITS:    counter_bits_in    = csr_data[K_WIDTH-1:0];
            CSR_LARGEST_ELEMENT: largest_element_in = csr_data[ELEMENT_WIDTH-1:0];
         endcase
      end
   end

   always_comb begin
      priority if (counter_bits_ff == '0) begin
         k_now = K_WIDTH'(1);
      end else if (counter_bits_ff > K_LARGEST) begin
         k_now = K_LARGEST;
      end else begin
         k_now = counter_bits_ff;
      end
      span     = SPAN_WIDTH'(req_element) * SPAN_WIDTH'(k_now);
      byte_idx = BW'(span >> 3);
      row_base = byte_idx >> 1;
      row_plus = row_base + BW'(1);
      even_rd_addr = RW'(byte_idx[0] ? row_plus : row_base);
      odd_rd_addr  = RW'(row_base);
      top_now  = OCC_WIDTH'((9'd1 << k_now) - 9'd1);
      sh_now   = SHIFT_WIDTH'(5'd16 - 5'(span[2:0]) - 5'(k_now));
      range_now = (32'(req_element) <= 32'(largest_element_ff))
               && (32'(req_element) < 32'(MAX_ELEMENTS));
      low_now  = (32'(byte_idx) + 32'd1) < 32'(MAX_ELEMENTS);
   end

   always_comb begin
      action_in    = action_ff;
      amount_in    = amount_ff;
      top_in       = top_ff;
      sh_in        = sh_ff;
      odd_first_in = odd_first_ff;
      low_ok_in    = low_ok_ff;
      range_ok_in  = range_ok_ff;
      even_addr_in = even_addr_ff;
      odd_addr_in  = odd_addr_ff;
      if (accept) begin
         action_in    = action_type'(req_action);
         amount_in    = req_amount;
         top_in       = top_now;
         sh_in        = sh_now;
         odd_first_in = byte_idx[0];
         low_ok_in    = low_now;
         range_ok_in  = range_now;
         even_addr_in = even_rd_addr;
         odd_addr_in  = odd_rd_addr;
      end
   end

   always_comb begin
      hi_byte = odd_first_ff ? odd_q : even_q;
      lo_byte = low_ok_ff ? (odd_first_ff ? even_q : odd_q) : 8'd0;
      window  = {hi_byte, lo_byte};
      mask16  = WINDOW_WIDTH'(top_ff) << sh_ff;
      cur     = OCC_WIDTH'((window >> sh_ff) & WINDOW_WIDTH'(top_ff));
      unique case (action_ff)
         ACTION_ADD_ONE:    add = OCC_WIDTH'(1);
         ACTION_ADD_AMOUNT: add = amount_ff;
         default:           add = '0;
      endcase
      room = top_ff - cur;
      nxt  = (add >= room) ? top_ff : cur + add;
      window_new = (window & ~mask16) | ((WINDOW_WIDTH'(nxt) << sh_ff) & mask16);
      do_write   = updating && range_ok_ff && (nxt != cur);
   end

   always_comb begin
      even_we      = clearing || (do_write && (!odd_first_ff || low_ok_ff));
      odd_we       = clearing || (do_write && (odd_first_ff || low_ok_ff));
      even_wr_addr = clearing ? clr_row_ff : even_addr_ff;
      odd_wr_addr  = clearing ? clr_row_ff : odd_addr_ff;
      even_wr_data = clearing ? 8'd0 : (odd_first_ff ? window_new[7:0] : window_new[15:8]);
      odd_wr_data  = clearing ? 8'd0 : (odd_first_ff ? window_new[15:8] : window_new[7:0]);
   end

   always_comb begin
      rsp_valid_in = updating;
      rsp_occ_in   = range_ok_ff ? nxt : '0;
      priority if (!range_ok_ff) begin
         rsp_status_in = STATUS_OUT_OF_RANGE;
      end else if (nxt == top_ff) begin
         rsp_status_in = STATUS_SATURATED;
      end else begin
         rsp_status_in = STATUS_OK;
      end
   end

   pcm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_even_bank (
      .clock   (clock),
      .wr_en   (even_we),
      .wr_addr (even_wr_addr),
      .wr_data (even_wr_data),
      .rd_addr (even_rd_addr),
      .rd_data (even_q)
   );

   pcm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_odd_bank (
      .clock   (clock),
      .wr_en   (odd_we),
      .wr_addr (odd_wr_addr),
      .wr_data (odd_wr_data),
      .rd_addr (odd_rd_addr),
      .rd_data (odd_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_CLEAR;
         clr_row_ff         <= '0;
         counter_bits_ff    <= K_RESET;
         largest_element_ff <= LARGEST_RESET;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         clr_row_ff         <= clr_row_in;
         counter_bits_ff    <= counter_bits_in;
         largest_element_ff <= largest_element_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      amount_ff     <= amount_in;
      top_ff        <= top_in;
      sh_ff         <= sh_in;
      odd_first_ff  <= odd_first_in;
      low_ok_ff     <= low_ok_in;
      range_ok_ff   <= range_ok_in;
      even_addr_ff  <= even_addr_in;
      odd_addr_ff   <= odd_addr_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_occurrences = rsp_occ_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ----- hdl/pcm_checker.sv -----
// Port-level checker of the packed counter multiset and its bind statement.
`include "assert_macros.svh"

module pcm_checker import pcm_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_valid,
   input logic [OCC_WIDTH-1:0]    rsp_occurrences,
   input logic [STATUS_WIDTH-1:0] rsp_status
);

   logic beat, out_of_range;

   assign beat         = start && !busy;
   assign out_of_range = rsp_valid && (rsp_status == STATUS_OUT_OF_RANGE);

   `PCM_ASSERT(a_result_follows_beat, clock, reset, beat |-> ##2 rsp_valid, "A result is missing.")
   `PCM_ASSERT(a_result_cause, clock, reset, rsp_valid |-> $past(beat, 2), "A result had no beat.")
   `PCM_ASSERT(a_busy_after_beat, clock, reset, beat |=> busy, "Busy did not follow a beat.")
   `PCM_ASSERT(a_range_zero, clock, reset, out_of_range |-> rsp_occurrences == '0, "Count not zero.")
   `PCM_ASSERT_ALWAYS(a_quiet_reset, clock, $past(reset) |-> !rsp_valid, "A result followed reset.")

endmodule

bind packed_counter_multiset pcm_checker u_pcm_checker (.*);
